/* design/lev_pkg.sv */
`default_nettype none

package lev_pkg;

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned SYM_W   = 16;
  localparam int unsigned DIST_W  = 6;
  localparam int unsigned LIMIT_W = 6;

  localparam int unsigned APB_DW    = 32;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_DISTANCE_LIMIT = 1'b0;
  localparam logic [LIMIT_W-1:0]   LIMIT_RESET        = 6'd1;

  localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SECOND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SYM_W-1:0]  symbol;
  } item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              within_limit;
    logic              overflow;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROW,
    ST_END_RD,
    ST_END_OUT
  } state_e;

  typedef struct packed {
    logic load_first;
    logic set_ovf;
    logic cnt_inc;
    logic row_start;
    logic row_step;
    logic rd_end;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic first_empty;
    logic first_full;
    logic second_empty;
    logic second_full;
    logic row_last;
  } dp_status_t;

endpackage

`default_nettype wire

/* design/lev_ram.sv */
`default_nettype none

module lev_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* design/lev_ctrl.sv */
`default_nettype none

module lev_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [lev_pkg::KIND_W-1:0] kind_i,
  input  wire lev_pkg::dp_status_t        status_i,
  output lev_pkg::ctrl_cmd_t              cmd_o,
  output logic                            busy_o
);

  lev_pkg::state_e state_q, state_d;
  logic            accept;

  assign busy_o = (state_q != lev_pkg::ST_IDLE);
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lev_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      lev_pkg::ST_IDLE: begin
        if (accept) begin
          priority if (kind_i == lev_pkg::KIND_FIRST) begin
            if (status_i.second_empty) begin
              if (status_i.first_full) begin
                cmd_o.set_ovf = 1'b1;
              end else begin
                cmd_o.load_first = 1'b1;
              end
            end
          end else if (kind_i == lev_pkg::KIND_SECOND) begin
            if (status_i.second_full) begin
              cmd_o.set_ovf = 1'b1;
            end else if (status_i.first_empty) begin
              cmd_o.cnt_inc = 1'b1;
            end else begin
              cmd_o.row_start = 1'b1;
              state_d         = lev_pkg::ST_ROW;
            end
          end else if (kind_i == lev_pkg::KIND_END) begin
            state_d = lev_pkg::ST_END_RD;
          end else begin
            state_d = lev_pkg::ST_IDLE;
          end
        end
      end
      lev_pkg::ST_ROW: begin
        cmd_o.row_step = 1'b1;
        if (status_i.row_last) begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = lev_pkg::ST_IDLE;
        end
      end
      lev_pkg::ST_END_RD: begin
        cmd_o.rd_end = 1'b1;
        state_d      = lev_pkg::ST_END_OUT;
      end
      lev_pkg::ST_END_OUT: begin
        cmd_o.emit = 1'b1;
        state_d    = lev_pkg::ST_IDLE;
      end
      default: begin
        state_d = lev_pkg::ST_IDLE;
      end
    endcase
  end

  a_row_needs_first_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lev_pkg::ST_ROW |-> !status_i.first_empty)
    else $error("row update running with an empty first word");

  a_end_read_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lev_pkg::ST_END_RD |=> state_q == lev_pkg::ST_END_OUT)
    else $error("end read not followed by result");

  a_row_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == lev_pkg::ST_ROW && status_i.row_last |=> state_q == lev_pkg::ST_IDLE)
    else $error("row update did not finish at the last cell");

endmodule

`default_nettype wire

/* design/lev_datapath.sv */
`default_nettype none

module lev_datapath #(
  parameter int unsigned MAX_LEN = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire lev_pkg::ctrl_cmd_t          cmd_i,
  input  wire lev_pkg::item_t              item_i,
  input  wire logic [lev_pkg::LIMIT_W-1:0] limit_i,
  output lev_pkg::dp_status_t              status_o,
  output logic                             done_o,
  output lev_pkg::result_t                 result_o
);

  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned EW = (LW > lev_pkg::DIST_W) ? LW : lev_pkg::DIST_W;

  logic [LW-1:0] first_len_q, second_cnt_q, idx_q;
  logic          ovf_q;
  logic [lev_pkg::SYM_W-1:0] sym_q;
  logic [LW-1:0] left_q, diag_q;
  logic          done_q;
  lev_pkg::result_t result_q;

  logic [LW-1:0] idx_m1, len_m1, above, cell_new, dist_raw;
  logic [LW:0]   del_c, ins_c, sub_c, min_a, min_b;
  logic [AW-1:0] raddr;
  logic          step_wr;
  logic [lev_pkg::SYM_W-1:0] fw_rdata;
  logic [LW-1:0] row_rdata;
  logic [EW-1:0] dist_ext;
  logic [lev_pkg::DIST_W-1:0] dist_sat;

  assign idx_m1  = idx_q - LW'(1);
  assign len_m1  = first_len_q - LW'(1);
  assign raddr   = cmd_i.rd_end ? len_m1[AW-1:0] : idx_q[AW-1:0];
  assign step_wr = cmd_i.row_step && (idx_q != '0);

  lev_ram #(
    .WIDTH (lev_pkg::SYM_W),
    .DEPTH (MAX_LEN)
  ) u_first_word (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_first),
    .waddr_i (first_len_q[AW-1:0]),
    .wdata_i (item_i.symbol),
    .re_i    (cmd_i.row_step),
    .raddr_i (raddr),
    .rdata_o (fw_rdata)
  );

  lev_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_LEN)
  ) u_row (
    .clk_i   (clk_i),
    .we_i    (step_wr),
    .waddr_i (idx_m1[AW-1:0]),
    .wdata_i (cell_new),
    .re_i    (cmd_i.row_step || cmd_i.rd_end),
    .raddr_i (raddr),
    .rdata_o (row_rdata)
  );

  // Before the first second-word symbol, row entry i still holds i.
  assign above = (second_cnt_q == '0) ? idx_q : row_rdata;
  assign del_c = {1'b0, left_q} + (LW+1)'(1);
  assign ins_c = {1'b0, above} + (LW+1)'(1);
  assign sub_c = {1'b0, diag_q} + (LW+1)'(fw_rdata != sym_q);
  assign min_a = (del_c < ins_c) ? del_c : ins_c;
  assign min_b = (min_a < sub_c) ? min_a : sub_c;
  assign cell_new = min_b[LW-1:0];

  always_comb begin
    if (first_len_q == '0) begin
      dist_raw = second_cnt_q;
    end else if (second_cnt_q == '0) begin
      dist_raw = first_len_q;
    end else begin
      dist_raw = row_rdata;
    end
  end

  assign dist_ext = EW'(dist_raw);
  assign dist_sat = (dist_ext > EW'(63)) ? '1 : dist_ext[lev_pkg::DIST_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_len_q  <= '0;
      second_cnt_q <= '0;
      ovf_q        <= 1'b0;
      idx_q        <= '0;
      done_q       <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
      if (cmd_i.emit) begin
        first_len_q  <= '0;
        second_cnt_q <= '0;
        ovf_q        <= 1'b0;
      end else begin
        if (cmd_i.load_first) begin
          first_len_q <= first_len_q + LW'(1);
        end
        if (cmd_i.cnt_inc) begin
          second_cnt_q <= second_cnt_q + LW'(1);
        end
        if (cmd_i.set_ovf) begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.row_start) begin
        idx_q <= '0;
      end else if (cmd_i.row_step) begin
        idx_q <= idx_q + LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.row_start) begin
      sym_q  <= item_i.symbol;
      diag_q <= second_cnt_q;
      left_q <= second_cnt_q + LW'(1);
    end else if (step_wr) begin
      left_q <= cell_new;
      diag_q <= above;
    end
    if (cmd_i.emit) begin
      result_q.distance     <= dist_sat;
      result_q.within_limit <= (dist_sat <= limit_i);
      result_q.overflow     <= ovf_q;
    end
  end

  assign status_o.first_empty  = (first_len_q == '0);
  assign status_o.first_full   = (first_len_q == LW'(MAX_LEN));
  assign status_o.second_empty = (second_cnt_q == '0);
  assign status_o.second_full  = (second_cnt_q == LW'(MAX_LEN));
  assign status_o.row_last     = (idx_q == first_len_q);

  assign done_o   = done_q;
  assign result_o = result_q;

  a_cleared_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> first_len_q == '0 && second_cnt_q == '0 && !ovf_q)
    else $error("pair state not cleared after result");

  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_len_q <= LW'(MAX_LEN) && second_cnt_q <= LW'(MAX_LEN))
    else $error("word length beyond maximum");

  a_no_first_after_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_first |-> second_cnt_q == '0)
    else $error("first-word symbol stored after second-word symbols");

endmodule

`default_nettype wire

/* design/levenshtein_distance_unit.sv */
// Channel   Direction  Handshake               Payload
// item      in         start && !busy          item_i (kind, symbol)
// result    out        done_o, one cycle       result_o (distance, within_limit, overflow)
// config    in         APB, write on access    distance_limit at byte address 0
//
// A first-word symbol is taken without leaving idle. A second-word symbol moves from idle to the
// row state, which issues the first read and then updates one row cell per step through the
// row memory port; with an empty first word or a full second word the block stays idle.
// An end beat keeps busy high in the read and output states; done_o strobes in the cycle after.
// Reset needs no clearing pass; the block is idle and accepts a beat as soon as reset is released.
// Results cannot be stalled; done_o is high for exactly one cycle and result_o holds until the next.
`default_nettype none

module levenshtein_distance_unit #(
  parameter int unsigned MAX_LEN = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire lev_pkg::item_t                item_i,
  output logic                               done_o,
  output lev_pkg::result_t                   result_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lev_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [lev_pkg::APB_DW-1:0]    pwdata,
  output logic      [lev_pkg::APB_DW-1:0]    prdata,
  output logic                               pready
);

  logic [lev_pkg::LIMIT_W-1:0] limit_q;
  logic                        reg_hit;
  lev_pkg::ctrl_cmd_t          cmd;
  lev_pkg::dp_status_t         status;

  assign reg_hit = (paddr[lev_pkg::PADDR_W-1:2] == lev_pkg::REG_DISTANCE_LIMIT);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? lev_pkg::APB_DW'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= lev_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      limit_q <= pwdata[lev_pkg::LIMIT_W-1:0];
    end
  end

  lev_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .kind_i   (item_i.kind),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  lev_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (item_i),
    .limit_i  (limit_q),
    .status_o (status),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

/* test/tb_levenshtein_distance_unit.sv */
`default_nettype none

module tb_levenshtein_distance_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN      = 32;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = MAX_LEN + 8;
  localparam int BEATS_PER_PHASE = 330;
  localparam int ITEM_W       = $bits(lev_pkg::item_t);

  localparam logic [lev_pkg::KIND_W-1:0]  KIND_RSVD  = 2'd3;
  localparam logic [lev_pkg::PADDR_W-1:0] LIMIT_ADDR =
    lev_pkg::PADDR_W'(4 * lev_pkg::REG_DISTANCE_LIMIT);

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         start;
  logic                         busy;
  lev_pkg::item_t               item_i;
  logic                         done_o;
  lev_pkg::result_t             result_o;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [lev_pkg::PADDR_W-1:0]  paddr;
  logic [lev_pkg::APB_DW-1:0]   pwdata;
  logic [lev_pkg::APB_DW-1:0]   prdata;
  logic                         pready;

  logic [lev_pkg::SYM_W-1:0]    word1_mem [MAX_LEN];
  int                           dp_row [MAX_LEN+1];
  int                           word1_len;
  int                           word2_cnt;
  bit                           trunc_seen;
  logic [lev_pkg::LIMIT_W-1:0]  limit_q;
  lev_pkg::result_t             due_results[$];
  lev_pkg::result_t             want;

  int                  err_cnt = 0;
  int                  beats_sent = 0;
  int                  cycle_cnt = 0;
  int                  sender_idle_pct = 0;

  levenshtein_distance_unit #(.MAX_LEN(MAX_LEN)) dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .item_i,
    .done_o,
    .result_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always #4 clk_i = ~clk_i;

  function automatic void clear_pair();
    for (int i = 0; i <= MAX_LEN; i++) begin
      dp_row[i] = i;
    end
    word1_len  = 0;
    word2_cnt  = 0;
    trunc_seen = 1'b0;
  endfunction

  function automatic void advance_dp_row(logic [lev_pkg::SYM_W-1:0] sym);
    int diag;
    int above;
    int best;
    int sub;
    diag      = dp_row[0];
    dp_row[0] = diag + 1;
    for (int i = 1; i <= word1_len; i++) begin
      above = dp_row[i];
      best  = dp_row[i-1] + 1;
      if (above + 1 < best) begin
        best = above + 1;
      end
      sub = diag + ((word1_mem[i-1] == sym) ? 0 : 1);
      if (sub < best) begin
        best = sub;
      end
      dp_row[i] = best;
      diag      = above;
    end
  endfunction

  function automatic void lev_step(lev_pkg::item_t it);
    lev_pkg::result_t res;
    int               d;
    case (it.kind)
      lev_pkg::KIND_FIRST: begin
        if (word2_cnt == 0) begin
          if (word1_len < MAX_LEN) begin
            word1_mem[word1_len] = it.symbol;
            word1_len++;
          end else begin
            trunc_seen = 1'b1;
          end
        end
      end
      lev_pkg::KIND_SECOND: begin
        if (word2_cnt < MAX_LEN) begin
          advance_dp_row(it.symbol);
          word2_cnt++;
        end else begin
          trunc_seen = 1'b1;
        end
      end
      lev_pkg::KIND_END: begin
        d = dp_row[word1_len];
        if (d > 63) begin
          d = 63;
        end
        res.distance     = lev_pkg::DIST_W'(d);
        res.within_limit = (d <= limit_q);
        res.overflow     = trunc_seen;
        due_results      = {due_results, res};
        clear_pair();
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (due_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) begin
          $display("unexpected result: distance %0d within_limit %0b overflow %0b",
                   result_o.distance, result_o.within_limit, result_o.overflow);
        end
      end else begin
        want = due_results.pop_front();
        if (result_o.distance !== want.distance ||
            result_o.within_limit !== want.within_limit ||
            result_o.overflow !== want.overflow) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("result mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                     want.distance, want.within_limit, want.overflow,
                     result_o.distance, result_o.within_limit, result_o.overflow);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles", cycle_cnt);
      $display("levenshtein_distance_unit verification failed");
      $finish;
    end
  end

  task automatic send_beat(lev_pkg::item_t it);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy !== 1'b0);
    lev_step(it);
    if (it.kind != KIND_RSVD) begin
      beats_sent++;
    end
    if ($urandom_range(99) < sender_idle_pct) begin
      start  <= 1'b0;
      item_i <= lev_pkg::item_t'(ITEM_W'($urandom));
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  task automatic send_sym(logic [lev_pkg::KIND_W-1:0] kind, logic [lev_pkg::SYM_W-1:0] sym);
    if ($urandom_range(29) == 0) begin
      send_beat(lev_pkg::item_t'{KIND_RSVD, lev_pkg::SYM_W'($urandom)});
    end
    send_beat(lev_pkg::item_t'{kind, sym});
  endtask

  task automatic wait_idle();
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(bit wr, logic [lev_pkg::APB_DW-1:0] wdata,
                            output logic [lev_pkg::APB_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= LIMIT_ADDR;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_limit_reg();
    logic [lev_pkg::APB_DW-1:0] rdata;
    @(posedge clk_i);
    apb_access(1'b0, '0, rdata);
    if (rdata !== lev_pkg::APB_DW'(limit_q)) begin
      err_cnt++;
      if (err_cnt <= 10) begin
        $display("limit readback: expected %0d, got %0h", limit_q, rdata);
      end
    end
  endtask

  task automatic program_limit(logic [lev_pkg::LIMIT_W-1:0] lim);
    logic [lev_pkg::APB_DW-1:0] wdata;
    logic [lev_pkg::APB_DW-1:0] rdata;
    wdata = $urandom;
    wdata[lev_pkg::LIMIT_W-1:0] = lim;
    apb_access(1'b1, wdata, rdata);
    limit_q = lim;
    check_limit_reg();
  endtask

  function automatic logic [lev_pkg::SYM_W-1:0] pick_sym(logic [lev_pkg::SYM_W-1:0] base);
    if ($urandom_range(1) != 0) begin
      return base ^ lev_pkg::SYM_W'($urandom_range(3));
    end
    return lev_pkg::SYM_W'($urandom);
  endfunction

  function automatic int pick_len();
    if ($urandom_range(99) < 8) begin
      return $urandom_range(MAX_LEN + 3, MAX_LEN - 2);
    end
    return $urandom_range(10, 0);
  endfunction

  task automatic test_limit_reset_value();
    check_limit_reg();
  endtask

  task automatic test_directed_pairs();
    sender_idle_pct = 0;
    send_beat(lev_pkg::item_t'{lev_pkg::KIND_END, 16'h0000});
    send_beat(lev_pkg::item_t'{lev_pkg::KIND_FIRST, 16'h0000});
    send_beat(lev_pkg::item_t'{lev_pkg::KIND_FIRST, 16'hFFFF});
    send_beat(lev_pkg::item_t'{lev_pkg::KIND_END, 16'hFFFF});
    send_beat(lev_pkg::item_t'{lev_pkg::KIND_SECOND, 16'hFFFF});
    send_beat(lev_pkg::item_t'{lev_pkg::KIND_END, 16'h0000});
    send_beat(lev_pkg::item_t'{lev_pkg::KIND_FIRST, 16'hFFFF});
    send_beat(lev_pkg::item_t'{lev_pkg::KIND_FIRST, 16'h0000});
    send_beat(lev_pkg::item_t'{lev_pkg::KIND_SECOND, 16'hFFFF});
    send_beat(lev_pkg::item_t'{lev_pkg::KIND_FIRST, 16'h1234});
    send_beat(lev_pkg::item_t'{lev_pkg::KIND_SECOND, 16'h0001});
    send_beat(lev_pkg::item_t'{KIND_RSVD, 16'hABCD});
    send_beat(lev_pkg::item_t'{lev_pkg::KIND_END, 16'h5A5A});
    send_beat(lev_pkg::item_t'{lev_pkg::KIND_FIRST, 16'hAAAA});
    send_beat(lev_pkg::item_t'{lev_pkg::KIND_FIRST, 16'h5555});
    send_beat(lev_pkg::item_t'{lev_pkg::KIND_SECOND, 16'h5555});
    send_beat(lev_pkg::item_t'{lev_pkg::KIND_SECOND, 16'hAAAA});
    send_beat(lev_pkg::item_t'{lev_pkg::KIND_END, 16'h0000});
    start <= 1'b0;
  endtask

  task automatic test_random_pairs(int idle_pct, logic [lev_pkg::LIMIT_W-1:0] lim, int n);
    logic [lev_pkg::SYM_W-1:0] word_a[$];
    logic [lev_pkg::SYM_W-1:0] word_b[$];
    logic [lev_pkg::SYM_W-1:0] base;
    int                        stop_at;
    int                        len;
    int                        r;
    bit                        ended;
    wait_idle();
    program_limit(lim);
    sender_idle_pct = idle_pct;
    stop_at = beats_sent + n;
    ended = 1'b1;
    while (beats_sent < stop_at) begin
      base = lev_pkg::SYM_W'($urandom);
      word_a.delete();
      word_b.delete();
      len = pick_len();
      repeat (len) word_a = {word_a, pick_sym(base)};
      if ($urandom_range(2) != 0) begin
        foreach (word_a[i]) begin
          r = $urandom_range(9);
          if (r < 7) begin
            word_b = {word_b, word_a[i]};
          end else if (r == 7) begin
            word_b = {word_b, pick_sym(base)};
          end else if (r == 9) begin
            word_b = {word_b, pick_sym(base)};
            word_b = {word_b, word_a[i]};
          end
        end
        if ($urandom_range(3) == 0) begin
          word_b = {word_b, pick_sym(base)};
        end
      end else begin
        len = pick_len();
        repeat (len) word_b = {word_b, pick_sym(base)};
      end
      foreach (word_a[i]) begin
        send_sym(lev_pkg::KIND_FIRST, word_a[i]);
      end
      foreach (word_b[i]) begin
        send_sym(lev_pkg::KIND_SECOND, word_b[i]);
        if (i == 0 && $urandom_range(15) == 0) begin
          send_sym(lev_pkg::KIND_FIRST, lev_pkg::SYM_W'($urandom));
        end
      end
      ended = ($urandom_range(19) != 0);
      if (ended) begin
        send_sym(lev_pkg::KIND_END, lev_pkg::SYM_W'($urandom));
      end
    end
    if (!ended) begin
      send_sym(lev_pkg::KIND_END, lev_pkg::SYM_W'($urandom));
    end
    start <= 1'b0;
  endtask

  initial begin
    rst_ni  <= 1'b0;
    start   <= 1'b0;
    item_i  <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    limit_q = lev_pkg::LIMIT_RESET;
    clear_pair();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_limit_reset_value();
    test_directed_pairs();
    test_random_pairs(33, 6'd0, BEATS_PER_PHASE);
    test_random_pairs(45, 6'd63, BEATS_PER_PHASE);
    test_random_pairs(0, 6'd32, BEATS_PER_PHASE);
    test_random_pairs(0, lev_pkg::LIMIT_W'($urandom_range(8, 2)), BEATS_PER_PHASE);

    wait_idle();
    if (err_cnt == 0) begin
      $display("levenshtein_distance_unit verification clean");
    end else begin
      $display("levenshtein_distance_unit verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
